FILE: hdl/i2c_master_register_transfer_unit_assert.svh
// Assertion macros for the I2C register transfer unit checker.
`ifndef I2C_MASTER_REGISTER_TRANSFER_UNIT_ASSERT_SVH
`define I2C_MASTER_REGISTER_TRANSFER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/i2cm_pkg.sv
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam int unsigned MAX_READ_BYTES = 256;
  localparam int unsigned CNT_W = $clog2(MAX_READ_BYTES + 1);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] RD_BIT   = 8'h01;

  typedef enum logic [3:0] {
    SEG_IDLE,
    SEG_START1,
    SEG_ID,
    SEG_ADDR,
    SEG_DATA,
    SEG_REL,
    SEG_START2,
    SEG_IDR,
    SEG_RX,
    SEG_STOP
  } seg_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic       cmd_rejected;
  } res_t;

endpackage

FILE: hdl/i2cm_core.sv
`timescale 1ns / 1ps
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [1:0] req_type,
  input  logic [7:0] dev_id,
  input  logic [7:0] reg_addr,
  input  logic [7:0] wr_data,
  input  logic [8:0] read_count,
  input  logic       sda_in,
  output res_t       res
);

  seg_t             seg_r, seg_nxt;
  logic [2:0]       sub_r, sub_nxt;
  logic [3:0]       bit_cnt_r, bit_cnt_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             is_read_r, is_read_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [7:0]       data_r, data_nxt;
  logic             scl_r, scl_nxt;
  logic             sda_r, sda_nxt;

  logic             adv;
  seg_t             adv_seg;
  logic             got;
  logic             last;
  logic             rejected;
  logic [3:0]       bc_inc;
  logic [CNT_W-1:0] left_dec;
  int unsigned      cnt_sat;

  always_comb begin
    if (read_count == 9'd0) begin
      cnt_sat = 1;
    end else if (32'(read_count) > MAX_READ_BYTES) begin
      cnt_sat = MAX_READ_BYTES;
    end else begin
      cnt_sat = 32'(read_count);
    end
  end

  assign bc_inc   = bit_cnt_r + 4'd1;
  assign left_dec = (left_r != '0) ? left_r - CNT_W'(1) : left_r;

  always_comb begin
    case (seg_r)
      SEG_START1: adv_seg = SEG_ID;
      SEG_ID:     adv_seg = SEG_ADDR;
      SEG_ADDR:   adv_seg = is_read_r ? SEG_REL : SEG_DATA;
      SEG_DATA:   adv_seg = SEG_STOP;
      SEG_REL:    adv_seg = SEG_START2;
      SEG_START2: adv_seg = SEG_IDR;
      SEG_IDR:    adv_seg = SEG_RX;
      SEG_RX:     adv_seg = SEG_STOP;
      default:    adv_seg = SEG_IDLE;
    endcase
  end

  always_comb begin
    seg_nxt     = seg_r;
    sub_nxt     = sub_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    left_nxt    = left_r;
    is_read_nxt = is_read_r;
    id_nxt      = id_r;
    addr_nxt    = addr_r;
    data_nxt    = data_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    adv         = 1'b0;
    got         = 1'b0;
    last        = 1'b0;
    rejected    = 1'b0;

    if (step_en && (req_type == REQ_WRITE || req_type == REQ_READ)) begin
      if (seg_r != SEG_IDLE) begin
        rejected = 1'b1;
      end else begin
        id_nxt      = dev_id;
        addr_nxt    = reg_addr;
        data_nxt    = wr_data;
        is_read_nxt = (req_type == REQ_READ);
        left_nxt    = (req_type == REQ_READ) ? CNT_W'(cnt_sat) : '0;
        seg_nxt     = SEG_START1;
        sub_nxt     = 3'd0;
        bit_cnt_nxt = 4'd0;
        shift_nxt   = 8'd0;
      end
    end else if (step_en && req_type == REQ_TICK) begin
      case (seg_r)
        SEG_START1, SEG_START2: begin
          case (sub_r)
            3'd0:    begin sda_nxt = 1'b1; sub_nxt = 3'd1; end
            3'd1:    begin scl_nxt = 1'b1; sub_nxt = 3'd2; end
            3'd2:    begin sda_nxt = 1'b0; sub_nxt = 3'd3; end
            default: begin scl_nxt = 1'b0; adv = 1'b1; end
          endcase
        end
        SEG_ID, SEG_ADDR, SEG_DATA, SEG_IDR: begin
          case (sub_r)
            3'd0: begin
              sda_nxt = (shift_r & MSB_MASK) != 8'd0;
              sub_nxt = 3'd1;
            end
            3'd1: begin scl_nxt = 1'b1; sub_nxt = 3'd2; end
            3'd2: begin
              scl_nxt     = 1'b0;
              shift_nxt   = {shift_r[6:0], 1'b0};
              bit_cnt_nxt = bc_inc;
              sub_nxt     = (bc_inc < 4'd8) ? 3'd0 : 3'd3;
            end
            3'd3:    begin sda_nxt = 1'b1; sub_nxt = 3'd4; end
            3'd4:    begin scl_nxt = 1'b1; sub_nxt = 3'd5; end
            3'd5:    begin scl_nxt = 1'b0; sub_nxt = 3'd6; end
            default: begin sda_nxt = 1'b0; adv = 1'b1; end
          endcase
        end
        SEG_REL: begin
          if (sub_r == 3'd0) begin
            sda_nxt = 1'b1;
            sub_nxt = 3'd1;
          end else begin
            scl_nxt = 1'b1;
            adv     = 1'b1;
          end
        end
        SEG_RX: begin
          case (sub_r)
            3'd0: begin
              sda_nxt     = 1'b1;
              bit_cnt_nxt = 4'd0;
              shift_nxt   = 8'd0;
              sub_nxt     = 3'd1;
            end
            3'd1: begin
              scl_nxt     = 1'b1;
              shift_nxt   = {shift_r[6:0], sda_in};
              bit_cnt_nxt = bc_inc;
              got         = (bc_inc >= 4'd8);
              last        = (left_r <= CNT_W'(1));
              sub_nxt     = 3'd2;
            end
            3'd2: begin
              scl_nxt = 1'b0;
              sub_nxt = (bit_cnt_r < 4'd8) ? 3'd1 : 3'd3;
            end
            3'd3: begin
              sda_nxt = (left_r <= CNT_W'(1));
              sub_nxt = 3'd4;
            end
            3'd4: begin scl_nxt = 1'b1; sub_nxt = 3'd5; end
            default: begin
              scl_nxt  = 1'b0;
              left_nxt = left_dec;
              if (left_dec != '0) begin
                sub_nxt = 3'd0;
              end else begin
                adv = 1'b1;
              end
            end
          endcase
        end
        SEG_STOP: begin
          case (sub_r)
            3'd0:    begin sda_nxt = 1'b0; sub_nxt = 3'd1; end
            3'd1:    begin scl_nxt = 1'b1; sub_nxt = 3'd2; end
            default: begin sda_nxt = 1'b1; adv = 1'b1; end
          endcase
        end
        default: begin
        end
      endcase
    end

    if (adv) begin
      seg_nxt     = adv_seg;
      sub_nxt     = 3'd0;
      bit_cnt_nxt = 4'd0;
      case (adv_seg)
        SEG_ID:   shift_nxt = id_r;
        SEG_ADDR: shift_nxt = addr_r;
        SEG_DATA: shift_nxt = data_r;
        SEG_IDR:  shift_nxt = id_r | RD_BIT;
        default:  shift_nxt = 8'd0;
      endcase
    end
  end

  always_comb begin
    res.scl_level    = scl_nxt;
    res.sda_level    = sda_nxt;
    res.busy_res     = (seg_nxt != SEG_IDLE);
    res.rd_data      = got ? shift_nxt : 8'd0;
    res.rd_valid     = got;
    res.rd_last      = got && last;
    res.cmd_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r     <= SEG_IDLE;
      sub_r     <= 3'd0;
      bit_cnt_r <= 4'd0;
      shift_r   <= 8'd0;
      left_r    <= '0;
      is_read_r <= 1'b0;
      id_r      <= 8'd0;
      addr_r    <= 8'd0;
      data_r    <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
    end else begin
      seg_r     <= seg_nxt;
      sub_r     <= sub_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      left_r    <= left_nxt;
      is_read_r <= is_read_nxt;
      id_r      <= id_nxt;
      addr_r    <= addr_nxt;
      data_r    <= data_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
    end
  end

endmodule

FILE: hdl/i2cm_out_buf.sv
`timescale 1ns / 1ps
module i2cm_out_buf
  import i2cm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic can_take,
  output logic dout_valid,
  input  logic dout_ready,
  output res_t dout
);

  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic main_vld_r, main_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  logic pop;

  assign pop        = main_vld_r && dout_ready;
  assign can_take   = !skid_vld_r;
  assign dout_valid = main_vld_r;
  assign dout       = main_r;

  always_comb begin
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_nxt     = din;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = din;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

FILE: hdl/i2c_master_register_transfer_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in_       in_valid / in_ready    req_type, dev_id, reg_addr, wr_data, read_count, sda_in
// out_      out_valid / out_ready  scl_level, sda_level, busy_res, rd_data, rd_valid,
//                                  rd_last, cmd_rejected
//
// One transaction per clock while in_ready is high: a request updates the bus state
// and its result is registered in the same cycle.
// The sequencer state update is the loop that sets the rate.
// Synchronous active-low reset leaves the bus released and the sequencer idle.
// A two-entry output buffer keeps in_ready high while one result waits;
// in_ready drops only when both entries are full.
module i2c_master_register_transfer_unit
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_dev_id,
  input  logic [7:0] in_reg_addr,
  input  logic [7:0] in_wr_data,
  input  logic [8:0] in_read_count,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic [7:0] out_rd_data,
  output logic       out_rd_valid,
  output logic       out_rd_last,
  output logic       out_cmd_rejected
);

  logic accept;
  res_t step_res;
  res_t out_res;

  assign accept = in_valid && in_ready;

  i2cm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (accept),
    .req_type   (in_req_type),
    .dev_id     (in_dev_id),
    .reg_addr   (in_reg_addr),
    .wr_data    (in_wr_data),
    .read_count (in_read_count),
    .sda_in     (in_sda_in),
    .res        (step_res)
  );

  i2cm_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .din        (step_res),
    .can_take   (in_ready),
    .dout_valid (out_valid),
    .dout_ready (out_ready),
    .dout       (out_res)
  );

  assign out_scl_level    = out_res.scl_level;
  assign out_sda_level    = out_res.sda_level;
  assign out_busy_res     = out_res.busy_res;
  assign out_rd_data      = out_res.rd_data;
  assign out_rd_valid     = out_res.rd_valid;
  assign out_rd_last      = out_res.rd_last;
  assign out_cmd_rejected = out_res.cmd_rejected;

endmodule

FILE: hdl/i2cm_checker.sv
`timescale 1ns / 1ps
`include "i2c_master_register_transfer_unit_assert.svh"
module i2cm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_scl_level,
  input logic       out_sda_level,
  input logic       out_busy_res,
  input logic       out_rd_valid,
  input logic       out_rd_last,
  input logic       out_cmd_rejected
);

  `I2CM_ASSERT_NOW(a_rd_in_xfer, out_valid && out_rd_valid, out_busy_res && out_sda_level && out_scl_level, "read byte outside a transfer")
  `I2CM_ASSERT_NOW(a_last_has_data, out_valid && out_rd_last, out_rd_valid, "last flag without read byte")
  `I2CM_ASSERT_NOW(a_reject_busy, out_valid && out_cmd_rejected, out_busy_res, "command rejected while idle")
  `I2CM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_scl_level) && $stable(out_sda_level), "stalled result changed")

endmodule

bind i2c_master_register_transfer_unit i2cm_checker u_i2cm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_scl_level    (out_scl_level),
  .out_sda_level    (out_sda_level),
  .out_busy_res     (out_busy_res),
  .out_rd_valid     (out_rd_valid),
  .out_rd_last      (out_rd_last),
  .out_cmd_rejected (out_cmd_rejected)
);

FILE: tb/tb_i2c_master_register_transfer_unit.sv
`timescale 1ns / 1ps
module tb_i2c_master_register_transfer_unit;
  import i2cm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned CALM_ITEMS   = 200;
  localparam logic [1:0]  REQ_NONE     = 2'd3;

  typedef enum int unsigned {SDA_LOW, SDA_HIGH, SDA_TOGGLE, SDA_RANDOM} sda_mode_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_req_type;
  logic [7:0] in_dev_id;
  logic [7:0] in_reg_addr;
  logic [7:0] in_wr_data;
  logic [8:0] in_read_count;
  logic       in_sda_in;
  logic       out_valid;
  logic       out_ready;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_busy_res;
  logic [7:0] out_rd_data;
  logic       out_rd_valid;
  logic       out_rd_last;
  logic       out_cmd_rejected;

  seg_t        bm_seg;
  int unsigned bm_sub;
  logic [3:0]  bm_bits;
  logic [7:0]  bm_shift;
  logic [8:0]  bm_left;
  logic        bm_read;
  logic [7:0]  bm_id;
  logic [7:0]  bm_addr;
  logic [7:0]  bm_data;
  logic        bm_scl;
  logic        bm_sda;

  res_t        pending_bus_states[$];
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned sent_items;
  bit          idling_on = 1'b1;

  i2c_master_register_transfer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_dev_id        (in_dev_id),
    .in_reg_addr      (in_reg_addr),
    .in_wr_data       (in_wr_data),
    .in_read_count    (in_read_count),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_level    (out_scl_level),
    .out_sda_level    (out_sda_level),
    .out_busy_res     (out_busy_res),
    .out_rd_data      (out_rd_data),
    .out_rd_valid     (out_rd_valid),
    .out_rd_last      (out_rd_last),
    .out_cmd_rejected (out_cmd_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void bus_reset();
    bm_seg   = SEG_IDLE;
    bm_sub   = 0;
    bm_bits  = '0;
    bm_shift = '0;
    bm_left  = '0;
    bm_read  = 1'b0;
    bm_id    = '0;
    bm_addr  = '0;
    bm_data  = '0;
    bm_scl   = 1'b1;
    bm_sda   = 1'b1;
  endfunction

  function automatic void bus_enter(seg_t seg);
    bm_seg  = seg;
    bm_sub  = 0;
    bm_bits = '0;
    case (seg)
      SEG_ID:   bm_shift = bm_id;
      SEG_ADDR: bm_shift = bm_addr;
      SEG_DATA: bm_shift = bm_data;
      SEG_IDR:  bm_shift = bm_id | RD_BIT;
      default:  bm_shift = '0;
    endcase
  endfunction

  function automatic void bus_advance();
    case (bm_seg)
      SEG_START1: bus_enter(SEG_ID);
      SEG_ID:     bus_enter(SEG_ADDR);
      SEG_ADDR:   bus_enter(bm_read ? SEG_REL : SEG_DATA);
      SEG_DATA:   bus_enter(SEG_STOP);
      SEG_REL:    bus_enter(SEG_START2);
      SEG_START2: bus_enter(SEG_IDR);
      SEG_IDR:    bus_enter(SEG_RX);
      SEG_RX:     bus_enter(SEG_STOP);
      default:    bus_enter(SEG_IDLE);
    endcase
  endfunction

  function automatic res_t bus_line_step(logic [1:0] req, logic [7:0] id, logic [7:0] addr,
                                         logic [7:0] data, logic [8:0] cnt, logic sda_bit);
    res_t       r;
    logic [8:0] n;
    r = '0;
    n = cnt;
    if (req == REQ_WRITE || req == REQ_READ) begin
      if (bm_seg != SEG_IDLE) begin
        r.cmd_rejected = 1'b1;
      end else begin
        bm_id   = id;
        bm_addr = addr;
        bm_data = data;
        bm_read = (req == REQ_READ);
        if (n == 0) n = 9'd1;
        if (n > MAX_READ_BYTES) n = 9'(MAX_READ_BYTES);
        bm_left = bm_read ? n : '0;
        bus_enter(SEG_START1);
      end
    end else if (req == REQ_TICK && bm_seg != SEG_IDLE) begin
      case (bm_seg)
        SEG_START1, SEG_START2: begin
          if (bm_sub == 0) begin
            bm_sda = 1'b1; bm_sub = 1;
          end else if (bm_sub == 1) begin
            bm_scl = 1'b1; bm_sub = 2;
          end else if (bm_sub == 2) begin
            bm_sda = 1'b0; bm_sub = 3;
          end else begin
            bm_scl = 1'b0; bus_advance();
          end
        end
        SEG_ID, SEG_ADDR, SEG_DATA, SEG_IDR: begin
          if (bm_sub == 0) begin
            bm_sda = (bm_shift & MSB_MASK) != 0; bm_sub = 1;
          end else if (bm_sub == 1) begin
            bm_scl = 1'b1; bm_sub = 2;
          end else if (bm_sub == 2) begin
            bm_scl   = 1'b0;
            bm_shift = bm_shift << 1;
            bm_bits  = bm_bits + 4'd1;
            bm_sub   = (bm_bits < 8) ? 0 : 3;
          end else if (bm_sub == 3) begin
            bm_sda = 1'b1; bm_sub = 4;
          end else if (bm_sub == 4) begin
            bm_scl = 1'b1; bm_sub = 5;
          end else if (bm_sub == 5) begin
            bm_scl = 1'b0; bm_sub = 6;
          end else begin
            bm_sda = 1'b0; bus_advance();
          end
        end
        SEG_REL: begin
          if (bm_sub == 0) begin
            bm_sda = 1'b1; bm_sub = 1;
          end else begin
            bm_scl = 1'b1; bus_advance();
          end
        end
        SEG_RX: begin
          if (bm_sub == 0) begin
            bm_sda = 1'b1; bm_bits = '0; bm_shift = '0; bm_sub = 1;
          end else if (bm_sub == 1) begin
            bm_scl   = 1'b1;
            bm_shift = {bm_shift[6:0], sda_bit};
            bm_bits  = bm_bits + 4'd1;
            if (bm_bits >= 8) begin
              r.rd_valid = 1'b1;
              r.rd_data  = bm_shift;
              r.rd_last  = (bm_left <= 1);
            end
            bm_sub = 2;
          end else if (bm_sub == 2) begin
            bm_scl = 1'b0; bm_sub = (bm_bits < 8) ? 1 : 3;
          end else if (bm_sub == 3) begin
            bm_sda = (bm_left <= 1); bm_sub = 4;
          end else if (bm_sub == 4) begin
            bm_scl = 1'b1; bm_sub = 5;
          end else begin
            bm_scl = 1'b0;
            if (bm_left > 0) bm_left = bm_left - 9'd1;
            if (bm_left > 0) bm_sub = 0;
            else bus_advance();
          end
        end
        SEG_STOP: begin
          if (bm_sub == 0) begin
            bm_sda = 1'b0; bm_sub = 1;
          end else if (bm_sub == 1) begin
            bm_scl = 1'b1; bm_sub = 2;
          end else begin
            bm_sda = 1'b1; bus_enter(SEG_IDLE);
          end
        end
        default: ;
      endcase
    end
    r.scl_level = bm_scl;
    r.sda_level = bm_sda;
    r.busy_res  = (bm_seg != SEG_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bus_states.size() == 0) begin
        errors++;
        $display("%0t: transaction expected none actual scl %0b sda %0b busy %0b data %0h",
                 $time, out_scl_level, out_sda_level, out_busy_res, out_rd_data);
      end else begin
        want = pending_bus_states.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(out_scl_level));
        check_field("sda_level", 8'(want.sda_level), 8'(out_sda_level));
        check_field("busy_res", 8'(want.busy_res), 8'(out_busy_res));
        check_field("rd_data", want.rd_data, out_rd_data);
        check_field("rd_valid", 8'(want.rd_valid), 8'(out_rd_valid));
        check_field("rd_last", 8'(want.rd_last), 8'(out_rd_last));
        check_field("cmd_rejected", 8'(want.cmd_rejected), 8'(out_cmd_rejected));
      end
    end
  end

  initial begin
    int unsigned hold;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(1, 16);
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_i2c_master_register_transfer_unit: errors");
    $finish;
  end

  task automatic send_item(input logic [1:0] req, input logic [7:0] id, input logic [7:0] addr,
                           input logic [7:0] data, input logic [8:0] cnt, input logic sda_bit);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_dev_id     <= id;
    in_reg_addr   <= addr;
    in_wr_data    <= data;
    in_read_count <= cnt;
    in_sda_in     <= sda_bit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_bus_states.push_back(bus_line_step(req, id, addr, data, cnt, sda_bit));
    sent_items++;
  endtask

  task automatic send_tick(input logic sda_bit);
    send_item(REQ_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom), sda_bit);
  endtask

  // drive ticks until the transfer ends, with optional stray commands mixed in
  task automatic finish_transfer(input sda_mode_t mode, input int unsigned noise_pct);
    logic        sda_bit;
    int unsigned steps;
    steps = 0;
    while (bm_seg != SEG_IDLE) begin
      case (mode)
        SDA_LOW:    sda_bit = 1'b0;
        SDA_HIGH:   sda_bit = 1'b1;
        SDA_TOGGLE: sda_bit = steps[1];
        default:    sda_bit = 1'($urandom_range(0, 1));
      endcase
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0:       send_item(REQ_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                             9'($urandom), sda_bit);
          1:       send_item(REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                             9'($urandom), sda_bit);
          default: send_item(REQ_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                             9'($urandom), sda_bit);
        endcase
      end else begin
        send_tick(sda_bit);
      end
      steps++;
    end
  endtask

  task automatic test_idle_requests();
    send_tick(1'b0);
    send_tick(1'b1);
    send_item(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 1'b1);
    send_item(REQ_NONE, 8'h00, 8'h00, 8'h00, 9'h000, 1'b0);
  endtask

  task automatic test_write_transfer();
    send_item(REQ_WRITE, 8'hFF, 8'h00, 8'hFF, 9'h1FF, 1'b1);
    finish_transfer(SDA_HIGH, 0);
    send_item(REQ_WRITE, 8'h00, 8'hFF, 8'h00, 9'h000, 1'b0);
    finish_transfer(SDA_LOW, 0);
  endtask

  task automatic test_read_transfer();
    send_item(REQ_READ, 8'h00, 8'hFF, 8'h00, 9'd1, 1'b0);
    finish_transfer(SDA_HIGH, 0);
    send_item(REQ_READ, 8'hFE, 8'h5A, 8'hFF, 9'd2, 1'b1);
    finish_transfer(SDA_TOGGLE, 0);
    send_item(REQ_READ, 8'hA5, 8'h00, 8'h00, 9'd0, 1'b0);
    finish_transfer(SDA_LOW, 0);
  endtask

  task automatic test_busy_commands();
    send_item(REQ_READ, 8'h3C, 8'hC3, 8'h00, 9'd3, 1'b0);
    repeat (10) send_tick(1'($urandom_range(0, 1)));
    send_item(REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 1'b1);
    send_item(REQ_READ, 8'h00, 8'h00, 8'h00, 9'h100, 1'b0);
    send_item(REQ_NONE, 8'h55, 8'hAA, 8'h55, 9'h0AA, 1'b1);
    finish_transfer(SDA_RANDOM, 10);
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int unsigned pick;
    int unsigned size_pick;
    logic [8:0]  cnt;
    first = sent_items;
    while (sent_items - first < RANDOM_ITEMS) begin
      if (sent_items - first >= RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        size_pick = $urandom_range(0, 59);
        if (size_pick == 0) cnt = 9'($urandom_range(17, 32));
        else if (size_pick < 12) cnt = 9'($urandom_range(0, 16));
        else cnt = 9'($urandom_range(1, 4));
        send_item($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, 8'($urandom), 8'($urandom),
                  8'($urandom), cnt, 1'($urandom_range(0, 1)));
        finish_transfer(SDA_RANDOM, 3);
      end else begin
        send_item(pick < 92 ? REQ_TICK : REQ_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                  9'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_req_type   <= REQ_TICK;
    in_dev_id     <= '0;
    in_reg_addr   <= '0;
    in_wr_data    <= '0;
    in_read_count <= '0;
    in_sda_in     <= 1'b1;
    errors     = 0;
    sent_items = 0;
    bus_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_requests();
    test_write_transfer();
    test_read_transfer();
    test_busy_commands();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_bus_states.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_i2c_master_register_transfer_unit: clean");
    end else begin
      $display("tb_i2c_master_register_transfer_unit: errors");
    end
    $finish;
  end

endmodule
